FILE: hdl/kld_pkg.sv
// Shared types, constants and helpers for the keyboard line discipline core.
package kld_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int ADDR_W     = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);
    localparam int KEY_W      = 32;
    localparam int CHAR_W     = 8;
    localparam int CNT_W      = 16;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_KEY  = 2'd0,
        CMD_READ = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_PLAIN_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_MASK   = 1'd1;

    localparam logic [KEY_W-1:0] PLAIN_MASK_RST = 32'h0000_06FF;
    localparam logic [KEY_W-1:0] EXT_MASK_RST   = 32'h0000_0100;

    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE     = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [KEY_W-1:0]  BYTE_MASK    = 32'h0000_00FF;

    typedef struct packed {
        logic             stored;
        logic             pop;
        logic [LVL_W-1:0] level;
    } t_fifo_res;

    typedef struct packed {
        logic             valid;
        t_cmd             cmd;
        logic             stored;
        logic             pop;
        logic [CNT_W-1:0] req_count;
        logic [LVL_W-1:0] level;
    } t_s1;

    typedef struct packed {
        logic              key_stored;
        logic              echo_valid;
        logic [CHAR_W-1:0] echo_char;
        logic              newline_echo;
        logic              store_valid;
        logic [CNT_W-1:0]  store_offset;
        logic [CHAR_W-1:0] store_char;
        logic              line_done;
        logic [CNT_W-1:0]  done_count;
        logic [LVL_W-1:0]  fifo_level;
    } t_result;

    function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        if (a == ADDR_W'(FIFO_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = a + 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: hdl/kld_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/kld_fifo.sv
// Key filter and ring FIFO pointer control around the key byte memory.
module kld_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  kld_pkg::t_cmd              i_cmd,
    input  logic [kld_pkg::KEY_W-1:0]  i_key,
    input  logic [kld_pkg::KEY_W-1:0]  i_plain_mask,
    input  logic [kld_pkg::KEY_W-1:0]  i_ext_mask,
    output kld_pkg::t_fifo_res         o_res,
    output logic [kld_pkg::CHAR_W-1:0] o_rd_data
);
    import kld_pkg::*;

    logic [ADDR_W-1:0] r_head, n_head;
    logic [ADDR_W-1:0] r_tail, n_tail;
    logic [LVL_W-1:0]  r_count, n_count;
    logic              plain;
    logic              push;
    logic              pop;

    assign plain = ((i_key & i_ext_mask) == '0) && ((i_key & ~i_plain_mask) == '0);
    assign push  = i_accept && (i_cmd == CMD_KEY) && plain
                   && (r_count != LVL_W'(FIFO_DEPTH));
    assign pop   = i_accept && (i_cmd == CMD_TICK) && (r_count != '0);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (push) begin
            n_head  = next_addr(r_head);
            n_count = r_count + 1'b1;
        end else if (pop) begin
            n_tail  = next_addr(r_tail);
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    kld_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_head),
        .i_wdata (CHAR_W'(i_key & BYTE_MASK)),
        .i_re    (pop),
        .i_raddr (r_tail),
        .o_rdata (o_rd_data)
    );

    assign o_res.stored = push;
    assign o_res.pop    = pop;
    assign o_res.level  = n_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LVL_W'(FIFO_DEPTH))
        else $error("fifo count above depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty fifo with unequal pointers");

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && pop))
        else $error("push and pop in one cycle");

endmodule

FILE: hdl/kld_line.sv
// Line read state: echo, store, backspace and completion of an armed read.
module kld_line (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  kld_pkg::t_s1               i_s1,
    input  logic [kld_pkg::CHAR_W-1:0] i_ch,
    output kld_pkg::t_result           o_res
);
    import kld_pkg::*;

    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_xfer, n_xfer;
    t_result          res;

    always_comb begin
        res            = '0;
        n_rem          = r_rem;
        n_xfer         = r_xfer;
        res.key_stored = i_s1.stored;
        res.fifo_level = i_s1.level;
        if (i_s1.cmd == CMD_READ) begin
            n_rem  = i_s1.req_count;
            n_xfer = '0;
        end else if ((i_s1.cmd == CMD_TICK) && i_s1.pop && (r_rem != '0)) begin
            if ((i_ch >= CH_SPACE) && (i_ch <= CH_TILDE)) begin
                res.echo_valid   = 1'b1;
                res.echo_char    = i_ch;
                res.store_valid  = 1'b1;
                res.store_offset = r_xfer;
                res.store_char   = i_ch;
                n_xfer           = r_xfer + 1'b1;
                n_rem            = r_rem - 1'b1;
            end else if ((i_ch == CH_BACKSPACE) && (r_xfer != '0)) begin
                res.echo_valid = 1'b1;
                res.echo_char  = i_ch;
                n_xfer         = r_xfer - 1'b1;
                n_rem          = r_rem + 1'b1;
            end
            if ((i_ch == CH_NEWLINE) || (n_rem == '0)) begin
                res.newline_echo = 1'b1;
                res.line_done    = 1'b1;
                res.done_count   = n_xfer;
                n_rem            = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_xfer <= '0;
        end else if (i_adv) begin
            r_rem  <= n_rem;
            r_xfer <= n_xfer;
        end
    end

    assign o_res = res;

    a_store_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.store_valid |-> (res.echo_valid && (res.echo_char == res.store_char)))
        else $error("stored character not echoed");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && res.line_done) |=> (r_rem == '0))
        else $error("read still armed after line done");

endmodule

FILE: hdl/keyboard_line_input_discipline_core.sv
// Top level of the keyboard line discipline core.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+--------------------------------------------------
//  request | i_valid | o_stall | i_command, i_key_code, i_request_count
//  result  | o_valid | i_stall | o_key_stored .. o_fifo_level (one per request)
//  config  | i_cfg_we| -       | i_cfg_idx, i_cfg_wdata
//
// One request per cycle unless a result stalls; each passes r_s1, then r_out registers.
// The registered FIFO memory read puts the line update one stage after acceptance.
// Reset is synchronous, active low; it clears pointers and counters and reloads the masks.
// A stalled result holds; one more request waits in the line stage, then the input stalls.
module keyboard_line_input_discipline_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [kld_pkg::CMD_W-1:0]     i_command,
    input  logic [kld_pkg::KEY_W-1:0]     i_key_code,
    input  logic [kld_pkg::CNT_W-1:0]     i_request_count,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_key_stored,
    output logic                          o_echo_valid,
    output logic [kld_pkg::CHAR_W-1:0]    o_echo_char,
    output logic                          o_newline_echo,
    output logic                          o_store_valid,
    output logic [kld_pkg::CNT_W-1:0]     o_store_offset,
    output logic [kld_pkg::CHAR_W-1:0]    o_store_char,
    output logic                          o_line_done,
    output logic [kld_pkg::CNT_W-1:0]     o_done_count,
    output logic [kld_pkg::LVL_W-1:0]     o_fifo_level,
    input  logic                          i_cfg_we,
    input  logic [kld_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kld_pkg::KEY_W-1:0]     i_cfg_wdata
);
    import kld_pkg::*;

    logic [KEY_W-1:0] r_plain_mask;
    logic [KEY_W-1:0] r_ext_mask;
    t_cmd             cmd;
    logic             accept;
    logic             out_load;
    t_fifo_res        fifo_res;
    logic [CHAR_W-1:0] rd_data;
    t_s1              r_s1, n_s1;
    t_result          line_res;
    t_result          r_out;
    logic             r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plain_mask <= PLAIN_MASK_RST;
            r_ext_mask   <= EXT_MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PLAIN_MASK: r_plain_mask <= i_cfg_wdata;
                REG_EXT_MASK:   r_ext_mask   <= i_cfg_wdata;
                default:        r_plain_mask <= r_plain_mask;
            endcase
        end
    end

    assign cmd      = t_cmd'(i_command);
    assign out_load = r_s1.valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_s1.valid && !out_load;
    assign accept   = i_valid && !o_stall;

    kld_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_cmd        (cmd),
        .i_key        (i_key_code),
        .i_plain_mask (r_plain_mask),
        .i_ext_mask   (r_ext_mask),
        .o_res        (fifo_res),
        .o_rd_data    (rd_data)
    );

    always_comb begin
        n_s1 = r_s1;
        if (accept) begin
            n_s1.valid     = 1'b1;
            n_s1.cmd       = cmd;
            n_s1.stored    = fifo_res.stored;
            n_s1.pop       = fifo_res.pop;
            n_s1.req_count = i_request_count;
            n_s1.level     = fifo_res.level;
        end else if (out_load) begin
            n_s1.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    kld_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (out_load),
        .i_s1    (r_s1),
        .i_ch    (rd_data),
        .o_res   (line_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= line_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_key_stored   = r_out.key_stored;
    assign o_echo_valid   = r_out.echo_valid;
    assign o_echo_char    = r_out.echo_char;
    assign o_newline_echo = r_out.newline_echo;
    assign o_store_valid  = r_out.store_valid;
    assign o_store_offset = r_out.store_offset;
    assign o_store_char   = r_out.store_char;
    assign o_line_done    = r_out.line_done;
    assign o_done_count   = r_out.done_count;
    assign o_fifo_level   = r_out.fifo_level;

    a_load_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("result load lost");

    a_key_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_key_stored) |-> (!o_echo_valid && !o_store_valid && !o_line_done))
        else $error("stored key with line activity");

    a_done_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_line_done) |-> o_newline_echo)
        else $error("line done without newline echo");

endmodule
